FILE: hdl/nbtw_pkg.sv
`timescale 1ns / 1ps
package nbtw_pkg;

  localparam int NBTW_MAX_NESTING = 64;

  // tag types
  localparam logic [3:0] TAG_END      = 4'd0;
  localparam logic [3:0] TAG_BYTE     = 4'd1;
  localparam logic [3:0] TAG_SHORT    = 4'd2;
  localparam logic [3:0] TAG_INT      = 4'd3;
  localparam logic [3:0] TAG_LONG     = 4'd4;
  localparam logic [3:0] TAG_FLOAT    = 4'd5;
  localparam logic [3:0] TAG_DOUBLE   = 4'd6;
  localparam logic [3:0] TAG_BARRAY   = 4'd7;
  localparam logic [3:0] TAG_STRING   = 4'd8;
  localparam logic [3:0] TAG_LIST     = 4'd9;
  localparam logic [3:0] TAG_COMPOUND = 4'd10;
  localparam logic [3:0] TAG_IARRAY   = 4'd11;
  localparam logic [3:0] TAG_LARRAY   = 4'd12;
  localparam logic [7:0] TAG_MAX      = 8'd12;

  // byte roles
  localparam logic [3:0] ROLE_TAG      = 4'd0;
  localparam logic [3:0] ROLE_NLEN     = 4'd1;
  localparam logic [3:0] ROLE_NAME     = 4'd2;
  localparam logic [3:0] ROLE_SCALAR   = 4'd3;
  localparam logic [3:0] ROLE_COUNT    = 4'd4;
  localparam logic [3:0] ROLE_ABODY    = 4'd5;
  localparam logic [3:0] ROLE_SBODY    = 4'd6;
  localparam logic [3:0] ROLE_LTYPE    = 4'd7;
  localparam logic [3:0] ROLE_TRAILING = 4'd8;
  localparam logic [3:0] ROLE_IGNORED  = 4'd9;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_ROOT      = 3'd2;
  localparam logic [2:0] ERR_NEGATIVE  = 3'd3;
  localparam logic [2:0] ERR_LIST_END  = 3'd4;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED = 3'd6;

  typedef enum logic [3:0] {
    PH_ROOT, PH_TAG, PH_NLEN, PH_NAME, PH_SCALAR,
    PH_COUNT, PH_BODY, PH_SLEN, PH_SBODY, PH_LTYPE
  } phase_e;

  // follow-up work of a byte that is left pending while the core is busy
  typedef enum logic [1:0] {
    PEND_NONE, PEND_VD, PEND_BEGIN
  } pend_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } nbtw_in_t;

  typedef struct packed {
    logic [3:0] byte_role;
    logic [3:0] tag_type;
    logic [6:0] nest_level;
    logic [2:0] error_code;
    logic       done_res;
  } nbtw_out_t;

  // fcount of zero marks a compound frame
  typedef struct packed {
    logic [3:0]  ftype;
    logic [31:0] fcount;
  } frame_t;

  typedef struct packed {
    logic        pop;
    logic        upd;
    logic [31:0] cnt;
    logic        push;
    frame_t      frame;
  } stk_op_t;

  typedef struct packed {
    frame_t top;
    frame_t below;
  } stk_view_t;

endpackage

FILE: hdl/nbtw_frame_stack.sv
`timescale 1ns / 1ps
// Frame stack: top and next-below frames in registers, the rest in a RAM.
// One op per cycle: optional pop, then optional count update of the new top,
// then optional push.
module nbtw_frame_stack import nbtw_pkg::*; #(
  parameter int MAX_NESTING = NBTW_MAX_NESTING,
  parameter int DW = $clog2(MAX_NESTING + 2)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stk_op_t       op_i,
  output logic [DW-1:0] depth_o,
  output stk_view_t     view_o
);

  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  frame_t          mem [MAX_NESTING];
  frame_t          top_q, below_q, base, base_n;
  logic [DW-1:0]   depth_q, de, wi, ri;

  always_comb begin
    base   = op_i.pop ? below_q : top_q;
    base_n = base;
    if (op_i.upd) base_n.fcount = op_i.cnt;
    de = depth_q - DW'(op_i.pop);
    wi = de - DW'(1);
    ri = de - DW'(2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= op_i.push ? de + DW'(1) : de;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.push) begin
      if (de != '0) mem[wi[AW-1:0]] <= base_n;
      top_q   <= op_i.frame;
      below_q <= base_n;
    end else begin
      top_q <= base_n;
      if (op_i.pop && de >= DW'(2)) below_q <= mem[ri[AW-1:0]];
    end
  end

  assign depth_o      = depth_q;
  assign view_o.top   = top_q;
  assign view_o.below = below_q;

endmodule

FILE: hdl/nbt_structure_walker_core.sv
`timescale 1ns / 1ps
// Channel   Signals                              Beat
// in        in_valid_i / in_ready_o / in_data_i  one buffer byte
// out       out_valid_o / out_ready_i / out_data_o  one report per byte
// cfg       byte_order_we_i / byte_order_i       byte order bit, no wait
//
// One byte per cycle while the core is not busy and its output is not stalled.
// A byte whose value ends a list adds a pending step per list frame it closes,
// plus another when it is an End tag; a list of compounds adds a pending step at
// its first element. The frame stack can pop, update and push in a single op.
// Reset clears all control state; the frame RAM needs no clearing.
// A stalled output holds its report and blocks the next byte until it is taken.
module nbt_structure_walker_core import nbtw_pkg::*; #(
  parameter int MAX_NESTING = NBTW_MAX_NESTING
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      byte_order_we_i,
  input  logic      byte_order_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  nbtw_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nbtw_out_t out_data_o
);

  localparam int DW    = $clog2(MAX_NESTING + 2);
  localparam int SLOTS = MAX_NESTING + 1;

  logic            bo_q;
  phase_e          phase_q, phase_d;
  pend_e           pend_q, pend_d;
  logic [34:0]     bleft_q, bleft_d, bl;
  logic [31:0]     lcol_q, lcol_d, cnt;
  logic [2:0]      k_q, k_d;
  logic [3:0]      elem_q, elem_d, ctag_q, ctag_d;
  logic [2:0]      err_q, err_d;
  logic            fin_q, fin_d;
  logic [3:0]      hrole_q, hrole_d, htag_q, htag_d;
  logic            heob_q, heob_d;
  logic            ovalid_q, ovalid_d;
  nbtw_out_t       out_q, out_d;

  stk_op_t         op;
  stk_view_t       view;
  logic [DW-1:0]   depth, dbase, dnext;
  frame_t          base;

  logic            acc, busy, final_v, norm, eob;
  logic [3:0]      role, tag;
  logic            vd_req, vd_below, bp_req;
  logic [3:0]      bp_type;
  logic [7:0]      b;
  logic [1:0]      idx;

  nbtw_frame_stack #(
    .MAX_NESTING(MAX_NESTING),
    .DW         (DW)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .depth_o(depth),
    .view_o (view)
  );

  assign busy       = pend_q != PEND_NONE;
  assign in_ready_o = !busy && (!ovalid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;

  always_comb begin
    phase_d  = phase_q;
    pend_d   = PEND_NONE;
    bleft_d  = bleft_q;
    lcol_d   = lcol_q;
    k_d      = k_q;
    elem_d   = elem_q;
    ctag_d   = ctag_q;
    err_d    = err_q;
    fin_d    = fin_q;
    hrole_d  = hrole_q;
    htag_d   = htag_q;
    heob_d   = heob_q;
    ovalid_d = ovalid_q && !out_ready_i;
    out_d    = out_q;
    op       = '0;
    final_v  = 1'b0;
    norm     = 1'b0;
    eob      = heob_q;
    role     = hrole_q;
    tag      = htag_q;
    vd_req   = 1'b0;
    vd_below = 1'b0;
    bp_req   = 1'b0;
    bp_type  = view.top.ftype;
    bl       = bleft_q - 35'(bleft_q != '0);
    cnt      = '0;
    idx      = '0;
    base     = view.top;
    dbase    = depth;

    if (busy) begin
      final_v = 1'b1;
      norm    = 1'b1;
      if (pend_q == PEND_VD) vd_req = 1'b1;
      else bp_req = 1'b1;
    end else if (acc) begin
      final_v = 1'b1;
      eob     = in_data_i.end_of_buffer;
      role    = ROLE_IGNORED;
      tag     = TAG_END;
      if (err_q != ERR_NONE) begin
        role = ROLE_IGNORED;
      end else if (fin_q) begin
        role = ROLE_TRAILING;
      end else begin
        norm = 1'b1;
        tag  = ctag_q;
        unique case (phase_q)
          PH_ROOT, PH_TAG: begin
            role = ROLE_TAG;
            if (b > TAG_MAX) begin
              tag   = TAG_END;
              err_d = ERR_UNKNOWN;
            end else if (phase_q == PH_ROOT && b[3:0] != TAG_COMPOUND) begin
              tag   = b[3:0];
              err_d = ERR_ROOT;
            end else if (phase_q == PH_TAG && b == 8'd0) begin
              tag = TAG_END;
              if (depth == '0) fin_d = 1'b1;
              else begin
                vd_req   = 1'b1;
                vd_below = 1'b1;
              end
            end else begin
              tag     = b[3:0];
              ctag_d  = b[3:0];
              phase_d = PH_NLEN;
              bleft_d = 35'd2;
              lcol_d  = '0;
            end
          end
          PH_NLEN, PH_SLEN: begin
            role = (phase_q == PH_NLEN) ? ROLE_NLEN : ROLE_COUNT;
            idx  = 2'd2 - bleft_q[1:0];
            if (!bo_q) lcol_d = {lcol_q[23:0], b};
            else lcol_d = lcol_q | (32'(b) << {idx, 3'b000});
            bleft_d = bl;
            if (bl == '0) begin
              lcol_d = {16'd0, lcol_d[15:0]};
              if (lcol_d == '0) begin
                if (phase_q == PH_NLEN) begin
                  bp_req  = 1'b1;
                  bp_type = ctag_q;
                end else vd_req = 1'b1;
              end else begin
                phase_d = (phase_q == PH_NLEN) ? PH_NAME : PH_SBODY;
                bleft_d = 35'(lcol_d);
              end
            end
          end
          PH_NAME: begin
            role    = ROLE_NAME;
            bleft_d = bl;
            if (bl == '0) begin
              bp_req  = 1'b1;
              bp_type = ctag_q;
            end
          end
          PH_SCALAR, PH_BODY, PH_SBODY: begin
            role = (phase_q == PH_SCALAR) ? ROLE_SCALAR :
                   (phase_q == PH_BODY) ? ROLE_ABODY : ROLE_SBODY;
            bleft_d = bl;
            if (bl == '0) vd_req = 1'b1;
          end
          PH_COUNT: begin
            role = ROLE_COUNT;
            idx  = 2'(3'd4 - k_q);
            if (!bo_q) lcol_d = {lcol_q[23:0], b};
            else lcol_d = lcol_q | (32'(b) << {idx, 3'b000});
            k_d = k_q - 3'(k_q != '0);
            if (k_d == '0) begin
              cnt = lcol_d;
              if (cnt[31]) err_d = ERR_NEGATIVE;
              else if (ctag_q == TAG_LIST) begin
                if (cnt == '0) vd_req = 1'b1;
                else if (elem_q == TAG_END) err_d = ERR_LIST_END;
                else if (depth >= DW'(SLOTS)) err_d = ERR_TOO_DEEP;
                else begin
                  op.push  = 1'b1;
                  op.frame = '{ftype: elem_q, fcount: cnt};
                  if (elem_q == TAG_COMPOUND) pend_d = PEND_BEGIN;
                  else begin
                    bp_req  = 1'b1;
                    bp_type = elem_q;
                  end
                end
              end else begin
                unique case (ctag_q)
                  TAG_BARRAY: bleft_d = {3'b000, cnt};
                  TAG_IARRAY: bleft_d = {1'b0, cnt, 2'b00};
                  default:    bleft_d = {cnt, 3'b000};
                endcase
                if (bleft_d == '0) vd_req = 1'b1;
                else phase_d = PH_BODY;
              end
            end
          end
          PH_LTYPE: begin
            role = ROLE_LTYPE;
            tag  = TAG_LIST;
            if (b > TAG_MAX) err_d = ERR_UNKNOWN;
            else begin
              phase_d = PH_COUNT;
              lcol_d  = '0;
              k_d     = 3'd4;
              elem_d  = b[3:0];
            end
          end
          default: begin
            role = ROLE_IGNORED;
            tag  = TAG_END;
          end
        endcase
      end
    end

    // close a value: the frame below decides what follows
    if (vd_req) begin
      if (vd_below) begin
        base   = view.below;
        dbase  = depth - DW'(1);
        op.pop = 1'b1;
      end
      if (dbase == '0) fin_d = 1'b1;
      else if (base.fcount == '0) phase_d = PH_TAG;
      else if (base.fcount != 32'd1) begin
        op.upd  = 1'b1;
        op.cnt  = base.fcount - 32'd1;
        bp_req  = 1'b1;
        bp_type = base.ftype;
      end else if (vd_below) begin
        pend_d = PEND_VD;
      end else begin
        op.pop = 1'b1;
        if (depth == DW'(1)) fin_d = 1'b1;
        else pend_d = PEND_VD;
      end
    end

    if (bp_req) begin
      ctag_d = bp_type;
      unique case (bp_type)
        TAG_BYTE: begin phase_d = PH_SCALAR; bleft_d = 35'd1; end
        TAG_SHORT: begin phase_d = PH_SCALAR; bleft_d = 35'd2; end
        TAG_INT, TAG_FLOAT: begin phase_d = PH_SCALAR; bleft_d = 35'd4; end
        TAG_LONG, TAG_DOUBLE: begin phase_d = PH_SCALAR; bleft_d = 35'd8; end
        TAG_BARRAY, TAG_IARRAY, TAG_LARRAY: begin
          phase_d = PH_COUNT;
          lcol_d  = '0;
          k_d     = 3'd4;
          elem_d  = TAG_END;
        end
        TAG_STRING: begin phase_d = PH_SLEN; lcol_d = '0; bleft_d = 35'd2; end
        TAG_LIST: phase_d = PH_LTYPE;
        TAG_COMPOUND: begin
          if ((depth - DW'(op.pop)) >= DW'(SLOTS)) begin
            if (err_d == ERR_NONE) err_d = ERR_TOO_DEEP;
          end else begin
            op.push  = 1'b1;
            op.frame = '{ftype: TAG_COMPOUND, fcount: 32'd0};
            phase_d  = PH_TAG;
          end
        end
        default: if (err_d == ERR_NONE) err_d = ERR_LIST_END;
      endcase
    end

    // first error wins
    if (err_q != ERR_NONE) err_d = err_q;
    if (err_d != ERR_NONE) pend_d = PEND_NONE;

    dnext = depth - DW'(op.pop) + DW'(op.push);

    if (acc) begin
      hrole_d = role;
      htag_d  = tag;
      heob_d  = eob;
    end

    if (final_v && pend_d == PEND_NONE) begin
      if (norm && eob && !fin_d && err_d == ERR_NONE) err_d = ERR_TRUNCATED;
      ovalid_d         = 1'b1;
      out_d.byte_role  = role;
      out_d.tag_type   = tag;
      out_d.nest_level = (fin_d && err_d == ERR_NONE) ? 7'd0 : 7'(dnext);
      out_d.error_code = err_d;
      out_d.done_res   = fin_d && err_d == ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bo_q     <= 1'b0;
      phase_q  <= PH_ROOT;
      pend_q   <= PEND_NONE;
      bleft_q  <= '0;
      lcol_q   <= '0;
      k_q      <= '0;
      elem_q   <= '0;
      ctag_q   <= '0;
      err_q    <= ERR_NONE;
      fin_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (byte_order_we_i) bo_q <= byte_order_i;
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      bleft_q  <= bleft_d;
      lcol_q   <= lcol_d;
      k_q      <= k_d;
      elem_q   <= elem_d;
      ctag_q   <= ctag_d;
      err_q    <= err_d;
      fin_q    <= fin_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hrole_q <= hrole_d;
    htag_q  <= htag_d;
    heob_q  <= heob_d;
    out_q   <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

endmodule
